>>> src/crv_pkg.sv
// crv_pkg: shared types, codes and the crc-32 byte update for the record checker
// no dependencies
package crv_pkg;

    localparam logic [31:0] REC_MAGIC   = 32'h3142_5743;
    localparam logic [15:0] REC_VERSION = 16'd2;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    localparam logic [2:0]  MAX_SLOT_RST    = 3'd0;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8176;
    localparam logic [15:0] BUF_SIZE_RST    = 16'd65535;

    localparam int HDR_BYTES = 16;

    typedef enum logic [1:0] {
        CFG_EXPECTED_SLOT = 2'd0,
        CFG_PAYLOAD_LIMIT = 2'd1,
        CFG_BUFFER_SIZE   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_SLOT   = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_BAD_CRC    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] payload_length;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  expected_slot;
        logic [15:0] max_payload;
        logic [15:0] buffer_size;
    } t_cfg;

    // handshake between the pipeline stages
    typedef struct packed {
        logic in_valid;
        logic advance;
    } t_pipe_ctl;

    // reflected crc-32, one byte per call
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/crv_in_stage.sv
// crv_in_stage: input register for the byte stream
// depends on crv_pkg
module crv_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  crv_pkg::t_in_word i_in_word,
    input  logic              i_advance,
    output logic              o_valid,
    output crv_pkg::t_in_word o_word
);
    import crv_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     load;

    assign load       = !r_valid || i_advance;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_word <= i_in_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> src/crv_core.sv
// crv_core: record parser, header checks and payload crc
// depends on crv_pkg
module crv_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crv_pkg::t_pipe_ctl i_ctl,
    input  crv_pkg::t_in_word  i_word,
    input  crv_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    output crv_pkg::t_out_word o_res
);
    import crv_pkg::*;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_count, n_count;
    logic [31:0]  r_crc, n_crc;
    logic [127:0] r_hdr, n_hdr;

    t_phase       eff_phase;
    logic [15:0]  eff_count;
    logic [3:0]   idx;
    logic         step;
    logic         hdr_last;
    logic [15:0]  cnt_inc;
    logic [31:0]  crc_next;
    logic         bad_header, bad_slot, bad_length, pay_last, crc_good;
    logic [15:0]  pay_len;

    assign step      = i_ctl.in_valid && i_ctl.advance;
    assign eff_phase = i_word.record_start ? PH_HEADER : r_phase;
    assign eff_count = i_word.record_start ? 16'd0 : r_count;
    assign idx       = eff_count[3:0];
    assign hdr_last  = (idx == 4'(HDR_BYTES - 1));
    assign cnt_inc   = eff_count + 16'd1;
    assign crc_next  = crc_byte(r_crc, i_word.data_byte);
    assign pay_len   = r_hdr[63:48];

    // header with the current byte put in its lane
    always_comb begin
        n_hdr = r_hdr;
        for (int l = 0; l < HDR_BYTES; l++) begin
            if (idx == 4'(l)) begin
                n_hdr[l*8 +: 8] = i_word.data_byte;
            end
        end
    end

    assign bad_header = (n_hdr[31:0] != REC_MAGIC) || (n_hdr[47:32] != REC_VERSION);
    assign bad_slot   = (n_hdr[127:96] != {29'd0, i_cfg.expected_slot});
    assign bad_length = (n_hdr[63:48] == 16'd0) || (n_hdr[63:48] > i_cfg.max_payload)
                     || (n_hdr[63:48] >= i_cfg.buffer_size);
    assign pay_last   = (cnt_inc >= pay_len);
    assign crc_good   = (~crc_next == r_hdr[95:64]);

    // next state
    always_comb begin
        n_phase = eff_phase;
        n_count = eff_count;
        n_crc   = r_crc;
        case (eff_phase)
            PH_HEADER: begin
                if (!hdr_last) begin
                    n_count = {12'd0, idx} + 16'd1;
                end else if (bad_header || bad_slot || bad_length) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_PAYLOAD;
                    n_count = 16'd0;
                    n_crc   = CRC_INIT;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = crc_next;
                n_count = cnt_inc;
                if (pay_last) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // result
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.status         = ST_OK;
        o_res.payload_length = 16'd0;
        case (eff_phase)
            PH_HEADER: begin
                if (hdr_last) begin
                    if (bad_header) begin
                        o_res_valid  = i_ctl.in_valid;
                        o_res.status = ST_BAD_HEADER;
                    end else if (bad_slot) begin
                        o_res_valid  = i_ctl.in_valid;
                        o_res.status = ST_BAD_SLOT;
                    end else if (bad_length) begin
                        o_res_valid  = i_ctl.in_valid;
                        o_res.status = ST_BAD_LENGTH;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (pay_last) begin
                    o_res_valid = i_ctl.in_valid;
                    if (crc_good) begin
                        o_res.status         = ST_OK;
                        o_res.payload_length = pay_len;
                    end else begin
                        o_res.status = ST_BAD_CRC;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 16'd0;
            r_crc   <= CRC_INIT;
        end else if (step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && eff_phase == PH_HEADER) begin
            r_hdr <= n_hdr;
        end
    end

`ifndef SYNTH
    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && o_res_valid) |=> (r_phase == PH_DONE))
        else $error("phase not finished after a verdict");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OK) |-> (o_res.payload_length != 16'd0))
        else $error("ok verdict with zero length");

    a_fail_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |-> (o_res.payload_length == 16'd0))
        else $error("failed verdict carries a length");

    a_count_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_count < pay_len))
        else $error("payload count past record length");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_count < 16'(HDR_BYTES)))
        else $error("header count out of range");
`endif

endmodule

>>> src/crv_out_stage.sv
// crv_out_stage: result register toward the consumer
// depends on crv_pkg
module crv_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  crv_pkg::t_out_word i_res,
    output logic               o_advance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crv_pkg::t_out_word o_out_word
);
    import crv_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // pipeline moves when the result register is empty or being taken
    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_word <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

>>> src/config_record_verifier_top.sv
// the deciding byte waits in the input register, its verdict in the result register
// throughput: one byte word per cycle; only a stalled, full result register holds input
// the whole check and the byte-wide crc update sit between the input and result registers
// reset (i_rst_n low, synchronous): parser idle, counters cleared, crc all ones,
// expected_slot 0, max_payload 8176, buffer_size 65535; header storage not cleared
// depends on crv_pkg, crv_in_stage, crv_core, crv_out_stage
module config_record_verifier_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream in
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  crv_pkg::t_in_word  i_in_word,
    // verdict out
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crv_pkg::t_out_word o_out_word,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import crv_pkg::*;

    t_cfg      r_cfg;
    t_pipe_ctl ctl;
    t_in_word  stage_word;
    logic      stage_valid;
    logic      advance;
    logic      res_valid;
    t_out_word res;

    // configuration registers; writes to an unused index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_slot <= MAX_SLOT_RST;
            r_cfg.max_payload   <= MAX_PAYLOAD_RST;
            r_cfg.buffer_size   <= BUF_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_SLOT: r_cfg.expected_slot <= i_cfg_data[2:0];
                CFG_PAYLOAD_LIMIT: r_cfg.max_payload   <= i_cfg_data;
                CFG_BUFFER_SIZE:   r_cfg.buffer_size   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input word register
    crv_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_word     (stage_word)
    );

    assign ctl.in_valid = stage_valid;
    assign ctl.advance  = advance;

    // header capture, checks and payload crc
    crv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_word      (stage_word),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // verdict register, decouples the consumer's stall
    crv_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
